### hw/rtl/jfpi_pkg.sv
// shared types, constants and fixed-point helpers of the joint force pi controller
package jfpi_pkg;

   localparam int JOINTS   = 7;
   localparam int JOINT_AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int CFG_W    = 31;
   localparam int GAIN_W   = 17;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [32:0] NEG_G_Q16 = -33'sd642908;
   localparam logic [GAIN_W-1:0]  ONE_Q16   = 17'd65536;
   localparam logic signed [63:0] ROUND_HALF = 64'sd32768;

   localparam logic [CFG_W-1:0]  MAX_STEP_RESET = 31'd65536;
   localparam logic [GAIN_W-1:0] SMOOTH_RESET   = 17'd65;
   localparam logic [CFG_W-1:0]  MASS_RESET     = 31'd6554;
   localparam logic [CFG_W-1:0]  GAIN_RESET     = 31'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_STEP    = 3'd0,
      CSR_SMOOTH_GAIN = 3'd1,
      CSR_TGT_MASS    = 3'd2,
      CSR_TGT_P_GAIN  = 3'd3,
      CSR_TGT_I_GAIN  = 3'd4
   } csr_index_type;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_FF1   = 12'b000000000010,
      S_FF2   = 12'b000000000100,
      S_ERR   = 12'b000000001000,
      S_INT   = 12'b000000010000,
      S_PGAIN = 12'b000000100000,
      S_IGAIN = 12'b000001000000,
      S_CMD   = 12'b000010000000,
      S_LIMIT = 12'b000100000000,
      S_SM0   = 12'b001000000000,
      S_SM1   = 12'b010000000000,
      S_SM2   = 12'b100000000000
   } state_type;

   typedef struct packed {
      logic signed [31:0] bias;
      logic signed [31:0] err_sum;
   } mem_entry_type;

   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [JOINT_AW-1:0] addr;
      mem_entry_type       wdata;
   } mem_req_type;

   function automatic logic signed [34:0] sext35(input logic signed [31:0] x);
      return {{3{x[31]}}, x};
   endfunction

   function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
      logic [3:0] top;
      top = v[34:31];
      if (top == 4'b0000 || top == 4'b1111) begin
         return v[31:0];
      end else if (v[34]) begin
         return 32'sh80000000;
      end else begin
         return 32'sh7fffffff;
      end
   endfunction

   // floor(v / 65536 + 1/2), saturated to 32 bits
   function automatic logic signed [31:0] round_sat(input logic signed [63:0] v);
      logic signed [63:0] w;
      logic [16:0]        top;
      w   = v + ROUND_HALF;
      top = w[63:47];
      if (top == 17'h00000 || top == 17'h1ffff) begin
         return w[47:16];
      end else if (w[63]) begin
         return 32'sh80000000;
      end else begin
         return 32'sh7fffffff;
      end
   endfunction

endpackage

### hw/rtl/joint_force_pi_controller_core.sv
// top level of the joint force pi controller: sequencer, datapath and registers
//
// One joint transaction at a time. A run transaction steps through its states
// from acceptance to a loaded result, in an order set by the single shared
// multiplier that forms the feedforward, integral, P and I products in turn,
// and holds in the limit state while the previous result still waits to be
// taken; on a transaction marked last joint, the smoothing states update the
// smoothed mass and gains before the next transaction is taken. A capture
// transaction or one for a joint index outside the joint count is absorbed
// in its acceptance cycle. Per-joint bias and error sum live in a small
// synchronous memory that reads as zero until written. The result register
// lets a new transaction start while a result waits to be taken.
module joint_force_pi_controller_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [2:0]         req_joint,
   input  logic               req_last_joint,
   input  logic signed [31:0] req_measured_torque,
   input  logic signed [31:0] req_gravity_torque,
   input  logic signed [31:0] req_robot_desired_torque,
   input  logic signed [31:0] req_jacobian_z,
   input  logic [15:0]        req_period,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_out_joint,
   output logic signed [31:0] rsp_command_torque,
   output logic               rsp_out_last,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [30:0]        csr_data
);

   jfpi_pkg::state_type state_ff, state_in;

   logic [jfpi_pkg::CFG_W-1:0]  max_step_ff;
   logic [jfpi_pkg::GAIN_W-1:0] smooth_gain_ff;
   logic [jfpi_pkg::CFG_W-1:0]  tgt_mass_ff, tgt_p_ff, tgt_i_ff;

   logic signed [31:0] smass_ff, smass_in;
   logic signed [31:0] kp_ff, kp_in;
   logic signed [31:0] ki_ff, ki_in;
   logic [1:0]         sm_sel_ff, sm_sel_in;

   logic [2:0]         joint_ff, joint_in;
   logic               last_ff, last_in;
   logic signed [31:0] meas_ff, meas_in;
   logic signed [31:0] grav_ff, grav_in;
   logic signed [31:0] rdt_ff, rdt_in;
   logic signed [31:0] jac_ff, jac_in;
   logic [15:0]        per_ff, per_in;
   logic signed [31:0] bias_ff, bias_in;
   logic signed [31:0] sum_ff, sum_in;
   logic signed [31:0] ext_ff, ext_in;
   logic signed [31:0] ffw_ff, ffw_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] pterm_ff, pterm_in;
   logic signed [31:0] cmd_ff, cmd_in;
   logic signed [63:0] acc_ff, acc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_joint_ff, rsp_joint_in;
   logic signed [31:0] rsp_cmd_ff, rsp_cmd_in;
   logic               rsp_last_ff, rsp_last_in;

   jfpi_pkg::mem_req_type   mem_req;
   jfpi_pkg::mem_entry_type mem_rd;

   logic signed [32:0] mul_a, mul_b;
   logic signed [63:0] product;
   logic signed [31:0] prod_q;

   logic                        req_accept;
   logic                        joint_ok;
   logic                        rsp_free;
   logic [jfpi_pkg::GAIN_W-1:0] g_eff, g_comp;
   logic [jfpi_pkg::CFG_W-1:0]  sm_target;
   logic signed [31:0]          sm_cur;
   logic signed [31:0]          sm_result;
   logic signed [34:0]          diff, lim, lim_neg;
   logic signed [31:0]          limited;

   jfpi_joint_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd)
   );

   jfpi_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   assign req_stall  = (state_ff != jfpi_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign joint_ok   = ({1'b0, req_joint} < 4'(jfpi_pkg::JOINTS));
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign prod_q     = jfpi_pkg::round_sat(product);

   assign g_eff  = (smooth_gain_ff > jfpi_pkg::ONE_Q16) ? jfpi_pkg::ONE_Q16 : smooth_gain_ff;
   assign g_comp = jfpi_pkg::ONE_Q16 - g_eff;

   always_comb begin
      case (sm_sel_ff)
         2'd0:    begin sm_target = tgt_mass_ff; sm_cur = smass_ff; end
         2'd1:    begin sm_target = tgt_p_ff;    sm_cur = kp_ff;    end
         default: begin sm_target = tgt_i_ff;    sm_cur = ki_ff;    end
      endcase
   end

   assign sm_result = jfpi_pkg::round_sat(acc_ff + product);

   // rate limit around the robot desired torque
   always_comb begin
      diff    = jfpi_pkg::sext35(cmd_ff) - jfpi_pkg::sext35(rdt_ff);
      lim     = {4'b0000, max_step_ff};
      lim_neg = -lim;
      if (diff > lim) begin
         diff = lim;
      end
      if (diff < lim_neg) begin
         diff = lim_neg;
      end
      limited = jfpi_pkg::sat35(jfpi_pkg::sext35(rdt_ff) + diff);
   end

   always_comb begin
      state_in     = state_ff;
      smass_in     = smass_ff;
      kp_in        = kp_ff;
      ki_in        = ki_ff;
      sm_sel_in    = sm_sel_ff;
      joint_in     = joint_ff;
      last_in      = last_ff;
      meas_in      = meas_ff;
      grav_in      = grav_ff;
      rdt_in       = rdt_ff;
      jac_in       = jac_ff;
      per_in       = per_ff;
      bias_in      = bias_ff;
      sum_in       = sum_ff;
      ext_in       = ext_ff;
      ffw_in       = ffw_ff;
      err_in       = err_ff;
      pterm_in     = pterm_ff;
      cmd_in       = cmd_ff;
      acc_in       = acc_ff;
      rsp_joint_in = rsp_joint_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_req      = '0;
      mem_req.addr = req_joint[jfpi_pkg::JOINT_AW-1:0];
      mul_a        = '0;
      mul_b        = '0;

      unique case (state_ff)
         jfpi_pkg::S_IDLE: begin
            if (req_accept && joint_ok) begin
               if (req_mode) begin
                  mem_req.wr_en         = 1'b1;
                  mem_req.wdata.bias    = jfpi_pkg::sat35(
                     jfpi_pkg::sext35(req_measured_torque)
                     - jfpi_pkg::sext35(req_gravity_torque));
                  mem_req.wdata.err_sum = '0;
               end else begin
                  mem_req.rd_en = 1'b1;
                  joint_in      = req_joint;
                  last_in       = req_last_joint;
                  meas_in       = req_measured_torque;
                  grav_in       = req_gravity_torque;
                  rdt_in        = req_robot_desired_torque;
                  jac_in        = req_jacobian_z;
                  per_in        = req_period;
                  state_in      = jfpi_pkg::S_FF1;
               end
            end
         end
         jfpi_pkg::S_FF1: begin
            bias_in  = mem_rd.bias;
            sum_in   = mem_rd.err_sum;
            ext_in   = jfpi_pkg::sat35(jfpi_pkg::sext35(meas_ff) - jfpi_pkg::sext35(grav_ff)
                                       - jfpi_pkg::sext35(mem_rd.bias));
            mul_a    = {jac_ff[31], jac_ff};
            mul_b    = {smass_ff[31], smass_ff};
            state_in = jfpi_pkg::S_FF2;
         end
         jfpi_pkg::S_FF2: begin
            mul_a    = {prod_q[31], prod_q};
            mul_b    = jfpi_pkg::NEG_G_Q16;
            state_in = jfpi_pkg::S_ERR;
         end
         jfpi_pkg::S_ERR: begin
            ffw_in   = prod_q;
            err_in   = jfpi_pkg::sat35(jfpi_pkg::sext35(prod_q) - jfpi_pkg::sext35(ext_ff));
            state_in = jfpi_pkg::S_INT;
         end
         jfpi_pkg::S_INT: begin
            mul_a    = {17'd0, per_ff};
            mul_b    = {err_ff[31], err_ff};
            state_in = jfpi_pkg::S_PGAIN;
         end
         jfpi_pkg::S_PGAIN: begin
            sum_in   = jfpi_pkg::sat35(jfpi_pkg::sext35(sum_ff) + jfpi_pkg::sext35(prod_q));
            mul_a    = {kp_ff[31], kp_ff};
            mul_b    = {err_ff[31], err_ff};
            state_in = jfpi_pkg::S_IGAIN;
         end
         jfpi_pkg::S_IGAIN: begin
            pterm_in              = prod_q;
            mem_req.wr_en         = 1'b1;
            mem_req.addr          = joint_ff[jfpi_pkg::JOINT_AW-1:0];
            mem_req.wdata.bias    = bias_ff;
            mem_req.wdata.err_sum = sum_ff;
            mul_a                 = {ki_ff[31], ki_ff};
            mul_b                 = {sum_ff[31], sum_ff};
            state_in              = jfpi_pkg::S_CMD;
         end
         jfpi_pkg::S_CMD: begin
            cmd_in   = jfpi_pkg::sat35(jfpi_pkg::sext35(ffw_ff) + jfpi_pkg::sext35(pterm_ff)
                                       + jfpi_pkg::sext35(prod_q));
            state_in = jfpi_pkg::S_LIMIT;
         end
         jfpi_pkg::S_LIMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_joint_in = joint_ff;
               rsp_cmd_in   = limited;
               rsp_last_in  = last_ff;
               sm_sel_in    = 2'd0;
               state_in     = last_ff ? jfpi_pkg::S_SM0 : jfpi_pkg::S_IDLE;
            end
         end
         jfpi_pkg::S_SM0: begin
            mul_a    = {16'd0, g_eff};
            mul_b    = {2'b00, sm_target};
            state_in = jfpi_pkg::S_SM1;
         end
         jfpi_pkg::S_SM1: begin
            acc_in   = product;
            mul_a    = {16'd0, g_comp};
            mul_b    = {sm_cur[31], sm_cur};
            state_in = jfpi_pkg::S_SM2;
         end
         jfpi_pkg::S_SM2: begin
            case (sm_sel_ff)
               2'd0:    smass_in = sm_result;
               2'd1:    kp_in    = sm_result;
               default: ki_in    = sm_result;
            endcase
            if (sm_sel_ff == 2'd2) begin
               sm_sel_in = 2'd0;
               state_in  = jfpi_pkg::S_IDLE;
            end else begin
               sm_sel_in = sm_sel_ff + 2'd1;
               state_in  = jfpi_pkg::S_SM0;
            end
         end
         default: begin
            state_in = jfpi_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= jfpi_pkg::S_IDLE;
         rsp_valid_ff   <= 1'b0;
         sm_sel_ff      <= 2'd0;
         smass_ff       <= '0;
         kp_ff          <= '0;
         ki_ff          <= '0;
         max_step_ff    <= jfpi_pkg::MAX_STEP_RESET;
         smooth_gain_ff <= jfpi_pkg::SMOOTH_RESET;
         tgt_mass_ff    <= jfpi_pkg::MASS_RESET;
         tgt_p_ff       <= jfpi_pkg::GAIN_RESET;
         tgt_i_ff       <= jfpi_pkg::GAIN_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sm_sel_ff    <= sm_sel_in;
         smass_ff     <= smass_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         if (csr_write) begin
            unique case (csr_index)
               jfpi_pkg::CSR_MAX_STEP:    max_step_ff    <= csr_data;
               jfpi_pkg::CSR_SMOOTH_GAIN: smooth_gain_ff <= csr_data[jfpi_pkg::GAIN_W-1:0];
               jfpi_pkg::CSR_TGT_MASS:    tgt_mass_ff    <= csr_data;
               jfpi_pkg::CSR_TGT_P_GAIN:  tgt_p_ff       <= csr_data;
               jfpi_pkg::CSR_TGT_I_GAIN:  tgt_i_ff       <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      joint_ff     <= joint_in;
      last_ff      <= last_in;
      meas_ff      <= meas_in;
      grav_ff      <= grav_in;
      rdt_ff       <= rdt_in;
      jac_ff       <= jac_in;
      per_ff       <= per_in;
      bias_ff      <= bias_in;
      sum_ff       <= sum_in;
      ext_ff       <= ext_in;
      ffw_ff       <= ffw_in;
      err_ff       <= err_in;
      pterm_ff     <= pterm_in;
      cmd_ff       <= cmd_in;
      acc_ff       <= acc_in;
      rsp_joint_ff <= rsp_joint_in;
      rsp_cmd_ff   <= rsp_cmd_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_joint      = rsp_joint_ff;
   assign rsp_command_torque = rsp_cmd_ff;
   assign rsp_out_last       = rsp_last_ff;

endmodule

### hw/rtl/jfpi_joint_mem.sv
// per-joint bias and error-sum memory with registered read
module jfpi_joint_mem (
   input  logic                   clock,
   input  logic                   reset,
   input  jfpi_pkg::mem_req_type  mem_req,
   output jfpi_pkg::mem_entry_type rd_data
);

   jfpi_pkg::mem_entry_type          mem_ff [jfpi_pkg::JOINTS];
   logic [jfpi_pkg::JOINTS-1:0]      valid_ff;
   jfpi_pkg::mem_entry_type          rd_data_ff;
   logic                             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[mem_req.addr];
         end
      end
   end

   // never-written entries read as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

### hw/rtl/jfpi_mul.sv
// shared signed 33x33 multiplier with registered product
module jfpi_mul (
   input  logic               clock,
   input  logic signed [32:0] mul_a,
   input  logic signed [32:0] mul_b,
   output logic signed [63:0] product
);

   logic signed [65:0] full_prod;
   logic signed [63:0] product_ff;

   assign full_prod = mul_a * mul_b;

   always_ff @(posedge clock) begin
      product_ff <= full_prod[63:0];
   end

   assign product = product_ff;

endmodule
